// ----- rtl/lpfs_pkg.sv -----
// Shared constants, stage payload types and mode codes of the LED panel frame serializer.
package lpfs_pkg;

   // Panel geometry
   localparam int BLOCKS       = 6;
   localparam int PANELS       = 2;
   localparam int X_SIZE       = BLOCKS * 8;
   localparam int Y_SIZE       = PANELS * 8;
   localparam int PANEL_BYTES  = BLOCKS + 1;
   localparam int COLUMN_BYTES = PANELS * PANEL_BYTES;
   localparam int STREAM_BYTES = 8 * COLUMN_BYTES;

   // Frame store: one word per panel and column, one bit per row within the panel
   localparam int WORDS  = PANELS * X_SIZE;
   localparam int ADDR_W = $clog2(WORDS);

   // Field widths
   localparam int X_W    = 6;
   localparam int Y_W    = 4;
   localparam int IDX_W  = 7;
   localparam int DATA_W = 8;
   localparam int ROW_W  = 3;

   // Index math widths
   localparam int COL_W   = 3;
   localparam int PANEL_W = 4;
   localparam int K_W     = 5;
   localparam int CALC_W  = 16;

   // Item modes
   localparam logic MODE_WRITE = 1'b0;
   localparam logic MODE_READ  = 1'b1;

   typedef struct packed {
      logic              mode;
      logic              pix_ok;
      logic [ADDR_W-1:0] pix_addr;
      logic [ROW_W-1:0]  pix_bit;
      logic              pix_on;
      logic              in_range;
      logic [COL_W-1:0]  col_grp;
      logic [IDX_W-1:0]  rest;
   } stage_a_type;

   typedef struct packed {
      logic              mode;
      logic              pix_ok;
      logic [ADDR_W-1:0] pix_addr;
      logic [ROW_W-1:0]  pix_bit;
      logic              pix_on;
      logic [ADDR_W-1:0] rd_addr;
      logic              in_range;
      logic              sel;
      logic              odd;
      logic [COL_W-1:0]  col_grp;
   } stage_b_type;

   typedef struct packed {
      logic              mode;
      logic              in_range;
      logic              sel;
      logic              odd;
      logic [COL_W-1:0]  col_grp;
      logic [DATA_W-1:0] word;
   } stage_c_type;

endpackage

// ----- rtl/led_panel_frame_serializer.sv -----
// Top level of the LED panel frame serializer: pipeline control and output word formatting.
// Path: a read word passes the stage A, stage B, store and output registers to rsp_serial_byte.
// Throughput: one request word per cycle; the stages advance together whenever the output
//   register is empty or being taken, so a stall only freezes the pipe.
// Pixel writes flow through the same stages and produce no response word.
// Reset: synchronous; afterwards every frame store word is swept to zero with req_ready held low.
module led_panel_frame_serializer import lpfs_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_mode,
   input  logic [X_W-1:0]    req_pixel_x,
   input  logic [Y_W-1:0]    req_pixel_y,
   input  logic              req_pixel_on,
   input  logic [IDX_W-1:0]  req_byte_index,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [DATA_W-1:0] rsp_serial_byte
);

   logic              move;
   logic              take;
   logic              clearing;
   logic              b_valid;
   stage_b_type       b_stage;
   logic              c_valid;
   stage_c_type       c_stage;
   logic [DATA_W-1:0] word_rev;
   logic [DATA_W-1:0] byte_in;
   logic              rsp_valid_ff;
   logic [DATA_W-1:0] rsp_byte_ff;

   // Advance every stage while the output register can take a new word
   assign move      = !rsp_valid_ff || rsp_ready;
   assign req_ready = move && !clearing;
   assign take      = req_valid && req_ready;

   lpfs_decode u_decode (
      .clock          (clock),
      .reset          (reset),
      .move           (move),
      .take           (take),
      .req_mode       (req_mode),
      .req_pixel_x    (req_pixel_x),
      .req_pixel_y    (req_pixel_y),
      .req_pixel_on   (req_pixel_on),
      .req_byte_index (req_byte_index),
      .b_valid        (b_valid),
      .b_out          (b_stage)
   );

   lpfs_store u_store (
      .clock    (clock),
      .reset    (reset),
      .move     (move),
      .b_valid  (b_valid),
      .b_in     (b_stage),
      .clearing (clearing),
      .c_valid  (c_valid),
      .c_out    (c_stage)
   );

   // Odd panels shift rows in ascending order, so the stored word comes out bit-reversed;
   // even panels shift descending rows and keep the stored order.
   always_comb begin
      for (int i = 0; i < DATA_W; i++) begin
         word_rev[i] = c_stage.word[DATA_W-1-i];
      end
   end

   // Pick the output word: zero past the stream end, one-hot column select, or pixel data
   always_comb begin
      if (!c_stage.in_range) begin
         byte_in = '0;
      end else if (c_stage.sel) begin
         byte_in = DATA_W'(8'h80 >> c_stage.col_grp);
      end else if (c_stage.odd) begin
         byte_in = word_rev;
      end else begin
         byte_in = c_stage.word;
      end
   end

   // Drop write items here; only reads become response words
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (move) begin
         rsp_valid_ff <= c_valid && (c_stage.mode == MODE_READ);
      end
   end

   always_ff @(posedge clock) begin
      if (move) begin
         rsp_byte_ff <= byte_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_serial_byte = rsp_byte_ff;

   // No request is taken while the store is being swept
   a_no_take_clearing: assert property (@(posedge clock) disable iff (reset)
      clearing |-> !req_ready)
      else $error("request accepted during frame store clearing");

   // A pixel write leaving the pipe never produces a response word
   a_write_silent: assert property (@(posedge clock) disable iff (reset)
      move && c_valid && c_stage.mode == MODE_WRITE |=> !rsp_valid)
      else $error("pixel write produced a response word");

   // A column select word is one-hot
   a_sel_onehot: assert property (@(posedge clock) disable iff (reset)
      move && c_valid && c_stage.mode == MODE_READ && c_stage.in_range && c_stage.sel
      |=> $onehot(rsp_serial_byte))
      else $error("column select word is not one-hot");

   // A read past the stream end answers zero
   a_past_end_zero: assert property (@(posedge clock) disable iff (reset)
      move && c_valid && c_stage.mode == MODE_READ && !c_stage.in_range
      |=> rsp_serial_byte == '0)
      else $error("read past stream end answered nonzero");

endmodule

// ----- rtl/lpfs_decode.sv -----
// Two register stages that turn a request into a frame store address and format flags.
module lpfs_decode import lpfs_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              move,
   input  logic              take,
   input  logic              req_mode,
   input  logic [X_W-1:0]    req_pixel_x,
   input  logic [Y_W-1:0]    req_pixel_y,
   input  logic              req_pixel_on,
   input  logic [IDX_W-1:0]  req_byte_index,
   output logic              b_valid,
   output stage_b_type       b_out
);

   stage_a_type a_ff, a_in;
   stage_b_type b_ff, b_in;
   logic        a_valid_ff;
   logic        b_valid_ff;

   logic [CALC_W-1:0]  grp_rem;
   logic [COL_W-1:0]   grp_q;
   logic [CALC_W-1:0]  pan_rem;
   logic [PANEL_W-1:0] pan_q;
   logic [K_W-1:0]     k;
   int                 panel_i;
   int                 col_i;

   // Stage A: split the byte index into column group and remainder, map pixel writes
   always_comb begin
      grp_rem = CALC_W'(req_byte_index);
      grp_q   = '0;
      for (int b = COL_W - 1; b >= 0; b--) begin
         if (grp_rem >= CALC_W'(COLUMN_BYTES << b)) begin
            grp_rem  = grp_rem - CALC_W'(COLUMN_BYTES << b);
            grp_q[b] = 1'b1;
         end
      end
      a_in.mode     = req_mode;
      a_in.pix_ok   = (CALC_W'(req_pixel_x) < CALC_W'(X_SIZE))
                   && (CALC_W'(req_pixel_y) < CALC_W'(Y_SIZE));
      a_in.pix_addr = ADDR_W'(32'(req_pixel_y[Y_W-1:ROW_W]) * X_SIZE + 32'(req_pixel_x));
      a_in.pix_bit  = req_pixel_y[ROW_W-1:0];
      a_in.pix_on   = req_pixel_on;
      a_in.in_range = CALC_W'(req_byte_index) < CALC_W'(STREAM_BYTES);
      a_in.col_grp  = grp_q;
      a_in.rest     = IDX_W'(grp_rem);
   end

   // Stage B: split the remainder into panel and byte within panel, form the read address
   always_comb begin
      pan_rem = CALC_W'(a_ff.rest);
      pan_q   = '0;
      for (int b = PANEL_W - 1; b >= 0; b--) begin
         if (pan_rem >= CALC_W'(PANEL_BYTES << b)) begin
            pan_rem  = pan_rem - CALC_W'(PANEL_BYTES << b);
            pan_q[b] = 1'b1;
         end
      end
      k       = K_W'(pan_rem);
      panel_i = PANELS - 1 - int'(pan_q);
      if (panel_i[0]) begin
         col_i = (7 - int'(a_ff.col_grp)) + int'(k) * 8;
      end else begin
         col_i = X_SIZE - 1 - (7 - int'(a_ff.col_grp)) - int'(k) * 8;
      end
      b_in.mode     = a_ff.mode;
      b_in.pix_ok   = a_ff.pix_ok;
      b_in.pix_addr = a_ff.pix_addr;
      b_in.pix_bit  = a_ff.pix_bit;
      b_in.pix_on   = a_ff.pix_on;
      b_in.in_range = a_ff.in_range;
      b_in.sel      = (k == K_W'(BLOCKS));
      b_in.odd      = panel_i[0];
      b_in.col_grp  = a_ff.col_grp;
      if (a_ff.in_range && !b_in.sel) begin
         b_in.rd_addr = ADDR_W'(panel_i * X_SIZE + col_i);
      end else begin
         b_in.rd_addr = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else if (move) begin
         a_valid_ff <= take;
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (move) begin
         a_ff <= a_in;
         b_ff <= b_in;
      end
   end

   assign b_valid = b_valid_ff;
   assign b_out   = b_ff;

endmodule

// ----- rtl/lpfs_store.sv -----
// Frame store with clearing pass after reset; one pixel write or one word read per cycle while the pipe moves.
module lpfs_store import lpfs_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        move,
   input  logic        b_valid,
   input  stage_b_type b_in,
   output logic        clearing,
   output logic        c_valid,
   output stage_c_type c_out
);

   logic [DATA_W-1:0] mem [WORDS];
   logic              clearing_ff;
   logic [ADDR_W-1:0] clr_ff;
   logic              c_valid_ff;
   stage_c_type       c_ff;

   // Sweep the store to zero, one word a cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_ff      <= '0;
      end else if (clearing_ff) begin
         clr_ff <= clr_ff + 1'b1;
         if (clr_ff == ADDR_W'(WORDS - 1)) begin
            clearing_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (clearing_ff) begin
         mem[clr_ff] <= '0;
      end else if (move && b_valid && b_in.mode == MODE_WRITE && b_in.pix_ok) begin
         mem[b_in.pix_addr][b_in.pix_bit] <= b_in.pix_on;
      end
   end

   always_ff @(posedge clock) begin
      if (move) begin
         c_ff.word     <= mem[b_in.rd_addr];
         c_ff.mode     <= b_in.mode;
         c_ff.in_range <= b_in.in_range;
         c_ff.sel      <= b_in.sel;
         c_ff.odd      <= b_in.odd;
         c_ff.col_grp  <= b_in.col_grp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else if (move) begin
         c_valid_ff <= b_valid;
      end
   end

   assign clearing = clearing_ff;
   assign c_valid  = c_valid_ff;
   assign c_out    = c_ff;

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for the LED panel frame serializer: directed table plus random words.
module testbench;
   import lpfs_pkg::*;

   // Receiver hold-off length, watchdog limit and drain time after the last response
   localparam int HOLD_CYCLES  = 300;
   localparam int IDLE_LIMIT   = 4000;
   localparam int DRAIN_CYCLES = 10;
   localparam int RANDOM_WORDS = 650;
   localparam int MAX_REPORTS  = 10;

   // One request word; typed marks a directed row whose response byte is given by hand
   typedef struct {
      logic              mode;
      logic [X_W-1:0]    pixel_x;
      logic [Y_W-1:0]    pixel_y;
      logic              pixel_on;
      logic [IDX_W-1:0]  byte_index;
      bit                typed;
      logic [DATA_W-1:0] typed_byte;
   } panel_word_type;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   logic              req_mode;
   logic [X_W-1:0]    req_pixel_x;
   logic [Y_W-1:0]    req_pixel_y;
   logic              req_pixel_on;
   logic [IDX_W-1:0]  req_byte_index;
   logic              rsp_valid;
   logic              rsp_ready;
   logic [DATA_W-1:0] rsp_serial_byte;

   // Shadow picture, stream bytes still owed by the block, directed stimulus
   logic              frame_bits [Y_SIZE][X_SIZE];
   logic [DATA_W-1:0] owed_bytes [$];
   panel_word_type    directed_words [$];
   logic [DATA_W-1:0] oldest_byte;

   int  mismatches    = 0;
   int  idle_cycles   = 0;
   int  hold_requests = 0;
   int  holds_taken   = 0;
   int  hold_left     = 0;
   int  stall_left    = 0;
   bit  calm          = 1'b0;

   led_panel_frame_serializer i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_mode        (req_mode),
      .req_pixel_x     (req_pixel_x),
      .req_pixel_y     (req_pixel_y),
      .req_pixel_on    (req_pixel_on),
      .req_byte_index  (req_byte_index),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_serial_byte (rsp_serial_byte)
   );

   initial clock = 1'b0;
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Work out one stream byte from the shadow picture.
   // Column groups run 0..7; inside each, panels run highest first; each panel
   // group is BLOCKS data bytes followed by the one-hot column-select byte.
   function automatic logic [DATA_W-1:0] predict_serial_byte(input logic [IDX_W-1:0] index);
      int                idx;
      int                col_grp;
      int                rest;
      int                panel;
      int                k;
      int                j;
      int                row;
      int                col;
      logic [DATA_W-1:0] acc;
      idx = int'(index);
      acc = '0;
      // Index past the end of the stream reads as zero
      if (idx >= STREAM_BYTES) return '0;
      col_grp = idx / COLUMN_BYTES;
      rest    = idx % COLUMN_BYTES;
      panel   = PANELS - 1 - rest / PANEL_BYTES;
      k       = rest % PANEL_BYTES;
      if (k == BLOCKS) return 8'h80 >> col_grp;
      for (j = 0; j < 8; j++) begin
         // Odd panels shift rows upward; even panels shift rows downward with x mirrored
         if (panel % 2 == 1) begin
            row = panel * 8 + j;
            col = (7 - col_grp) + k * 8;
         end else begin
            row = panel * 8 + (7 - j);
            col = X_SIZE - 1 - (7 - col_grp) - k * 8;
         end
         // First shifted bit lands in the MSB
         acc[7 - j] = frame_bits[row][col];
      end
      return acc;
   endfunction

   // Gap length for either side: mostly none, some short, a few long; none while calm
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (calm) return 0;
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   // Draw one random word; a few pixel writes land outside the picture and a
   // few reads land past the stream, and unused fields carry noise.
   function automatic panel_word_type random_word(input int on_pct);
      panel_word_type w;
      w.mode     = ($urandom_range(0, 99) < 45) ? MODE_READ : MODE_WRITE;
      if ($urandom_range(0, 9) == 0)
         w.pixel_x = X_W'($urandom_range(X_SIZE, (1 << X_W) - 1));
      else
         w.pixel_x = X_W'($urandom_range(0, X_SIZE - 1));
      w.pixel_y  = Y_W'($urandom_range(0, (1 << Y_W) - 1));
      w.pixel_on = ($urandom_range(0, 99) < on_pct);
      if ($urandom_range(0, 9) == 0)
         w.byte_index = IDX_W'($urandom_range(STREAM_BYTES, (1 << IDX_W) - 1));
      else
         w.byte_index = IDX_W'($urandom_range(0, STREAM_BYTES - 1));
      w.typed      = 1'b0;
      w.typed_byte = '0;
      return w;
   endfunction

   task automatic add_directed(input logic mode, input int x, input int y, input logic on,
                               input int index, input bit typed, input logic [DATA_W-1:0] want);
      panel_word_type w;
      w.mode       = mode;
      w.pixel_x    = X_W'(x);
      w.pixel_y    = Y_W'(y);
      w.pixel_on   = on;
      w.byte_index = IDX_W'(index);
      w.typed      = typed;
      w.typed_byte = want;
      directed_words.push_back(w);
   endtask

   // Advance the shadow picture or record the byte a read word is owed
   task automatic apply_word(input panel_word_type w);
      if (w.mode == MODE_WRITE) begin
         // Drop writes outside the picture
         if (w.pixel_x < X_SIZE && w.pixel_y < Y_SIZE)
            frame_bits[w.pixel_y][w.pixel_x] = w.pixel_on;
      end else if (w.typed) begin
         owed_bytes.push_back(w.typed_byte);
      end else begin
         owed_bytes.push_back(predict_serial_byte(w.byte_index));
      end
   endtask

   // Offer one word: idle for a random gap, then hold valid and payload until taken.
   // Valid is only touched at a falling edge, once per edge.
   task automatic offer_word(input panel_word_type w);
      int gap;
      @(negedge clock);
      gap = pick_gap();
      if (gap != 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid      = 1'b1;
      req_mode       = w.mode;
      req_pixel_x    = w.pixel_x;
      req_pixel_y    = w.pixel_y;
      req_pixel_on   = w.pixel_on;
      req_byte_index = w.byte_index;
      do @(posedge clock); while (!req_ready);
      apply_word(w);
   endtask

   // Receiver: random stalls, plus a long hold-off whenever one is requested
   initial rsp_ready = 1'b0;
   always @(negedge clock) begin
      if (hold_requests != holds_taken) begin
         holds_taken = holds_taken + 1;
         hold_left   = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         rsp_ready = 1'b0;
         hold_left = hold_left - 1;
      end else if (stall_left > 0) begin
         rsp_ready  = 1'b0;
         stall_left = stall_left - 1;
      end else begin
         rsp_ready  = 1'b1;
         stall_left = pick_gap();
      end
   end

   // Compare each taken response word with the oldest owed byte
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (owed_bytes.size() == 0) begin
            mismatches = mismatches + 1;
            if (mismatches <= MAX_REPORTS)
               $display("unexpected response word: serial_byte %02h", rsp_serial_byte);
         end else begin
            oldest_byte = owed_bytes.pop_front();
            if (rsp_serial_byte !== oldest_byte) begin
               mismatches = mismatches + 1;
               if (mismatches <= MAX_REPORTS)
                  $display("serial_byte mismatch: expected %02h got %02h",
                           oldest_byte, rsp_serial_byte);
            end
         end
      end
   end

   // Watchdog: end the run once no word has moved on either side for too long
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   initial begin
      int n;
      int on_pct;
      int r;
      int c;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_mode       = MODE_WRITE;
      req_pixel_x    = '0;
      req_pixel_y    = '0;
      req_pixel_on   = 1'b0;
      req_byte_index = '0;
      for (r = 0; r < Y_SIZE; r++)
         for (c = 0; c < X_SIZE; c++)
            frame_bits[r][c] = 1'b0;

      // Directed rows: empty picture, column-select bytes, stream end, one full byte,
      // writes outside the picture, clearing a pixel, noise in unused fields
      add_directed(MODE_READ,   0,  0, 1'b0,   0, 1'b1, 8'h00);
      add_directed(MODE_READ,   0,  0, 1'b0,   6, 1'b1, 8'h80);
      add_directed(MODE_READ,   0,  0, 1'b0,  13, 1'b1, 8'h80);
      add_directed(MODE_READ,   0,  0, 1'b0, 111, 1'b1, 8'h01);
      add_directed(MODE_READ,   0,  0, 1'b0, 112, 1'b1, 8'h00);
      add_directed(MODE_READ,  63, 15, 1'b1, 127, 1'b1, 8'h00);
      for (r = 8; r < 16; r++)
         add_directed(MODE_WRITE, 47, r, 1'b1, (r == 15) ? 127 : 0, 1'b0, 8'h00);
      add_directed(MODE_READ,   0,  0, 1'b0,   5, 1'b1, 8'hFF);
      add_directed(MODE_WRITE,  0,  0, 1'b1, 127, 1'b0, 8'h00);
      add_directed(MODE_READ,   0,  0, 1'b0,  12, 1'b0, 8'h00);
      add_directed(MODE_WRITE, 63, 15, 1'b1,   0, 1'b0, 8'h00);
      add_directed(MODE_WRITE, 48,  0, 1'b1,   0, 1'b0, 8'h00);
      add_directed(MODE_READ,   0,  0, 1'b0,  12, 1'b0, 8'h00);
      add_directed(MODE_WRITE,  0,  0, 1'b0,   0, 1'b0, 8'h00);
      add_directed(MODE_READ,  47, 15, 1'b1,  12, 1'b0, 8'h00);
      add_directed(MODE_WRITE, 47, 15, 1'b0,   0, 1'b0, 8'h00);
      add_directed(MODE_READ,   0,  0, 1'b0,   5, 1'b0, 8'h00);

      // Hold reset, then release it at a falling edge; the block then sweeps its store with req_ready low
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed_words[i])
         offer_word(directed_words[i]);

      for (n = 0; n < RANDOM_WORDS; n++) begin
         // Run a stretch with no idling on either side
         calm = (n >= 100 && n < 180);
         // Hold off the receiver while words keep coming, so the pipe fills and stalls
         if (n == 200)
            hold_requests = hold_requests + 1;
         // Pause the sender until every owed byte has come back
         if (n == 400) begin
            @(negedge clock);
            req_valid = 1'b0;
            while (owed_bytes.size() != 0) @(negedge clock);
         end
         // Alternate between filling and clearing the picture
         on_pct = ((n / 130) % 2 == 0) ? 75 : 25;
         offer_word(random_word(on_pct));
      end

      @(negedge clock);
      req_valid = 1'b0;
      while (owed_bytes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0 && owed_bytes.size() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
